/* hdl/btss_pkg.sv */
// Shared types and constants of the backtrack thread stack scheduler.
// No dependencies; imported by btss_stack and the top level.
package btss_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int HANDLE_W        = 8;

	typedef enum logic [1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_IN_ORDER = 2'd1,
		CMD_NEXT     = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] thread_id;
	} req_t;

	typedef struct packed {
		logic                thread_valid;
		logic [HANDLE_W-1:0] thread_out;
		logic                overflow;
	} res_t;

endpackage

/* hdl/btss_stack.sv */
// Active slot, handle stack and in-order insert position of the scheduler.
// Depends on btss_pkg. The stack is a shift line with the top at cell 0.
module btss_stack import btss_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  req_t req,
	output res_t res
);

	localparam int CW = $clog2(STACK_DEPTH + 2);

	logic                active_valid_q;
	logic [HANDLE_W-1:0] active_handle_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       pos_q;
	logic [HANDLE_W-1:0] cell_q [STACK_DEPTH];

	logic                active_valid_d;
	logic [CW-1:0]       count_d;
	logic [CW-1:0]       pos_d;
	logic                do_ins;
	logic                do_pop;
	logic [CW-1:0]       ins_k;
	logic                full;
	logic [CW-1:0]       count_inc;

	assign full      = (count_q == CW'(STACK_DEPTH));
	assign count_inc = count_q + CW'(1);

	always_comb begin
		active_valid_d = active_valid_q;
		count_d        = count_q;
		pos_d          = pos_q;
		do_ins         = 1'b0;
		do_pop         = 1'b0;
		ins_k          = '0;
		res            = '0;
		case (req.cmd)
			CMD_SCHEDULE, CMD_IN_ORDER: begin
				if (req.cmd == CMD_SCHEDULE || pos_q > count_q) begin
					// plain schedule: fill the active slot, else push on top
					pos_d = (req.cmd == CMD_SCHEDULE) ? count_inc : count_q;
					if (!active_valid_q) begin
						active_valid_d = 1'b1;
					end else if (full) begin
						res.overflow = 1'b1;
					end else begin
						do_ins  = 1'b1;
						count_d = count_inc;
					end
				end else if (full) begin
					res.overflow = 1'b1;
				end else begin
					// insert at bottom index pos, which is top index count - pos
					do_ins  = 1'b1;
					ins_k   = count_q - pos_q;
					count_d = count_inc;
				end
			end
			CMD_NEXT: begin
				pos_d = count_inc;
				if (active_valid_q) begin
					active_valid_d   = 1'b0;
					res.thread_valid = 1'b1;
					res.thread_out   = active_handle_q;
				end else if (count_q != '0) begin
					do_pop           = 1'b1;
					count_d          = count_q - CW'(1);
					res.thread_valid = 1'b1;
					res.thread_out   = cell_q[0];
				end
			end
			CMD_CLEAR: begin
				active_valid_d = 1'b0;
				count_d        = '0;
				pos_d          = CW'(1);
			end
			default: begin
				active_valid_d = active_valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_valid_q <= 1'b0;
			count_q        <= '0;
			pos_q          <= '0;
		end else if (en) begin
			active_valid_q <= active_valid_d;
			count_q        <= count_d;
			pos_q          <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !active_valid_q && active_valid_d) begin
			active_handle_q <= req.thread_id;
		end
	end

	genvar g;
	for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(g);
		logic [HANDLE_W-1:0] ins_src;
		logic [HANDLE_W-1:0] pop_src;

		if (g == 0) begin : g_first
			assign ins_src = req.thread_id;
		end else begin : g_mid
			assign ins_src = cell_q[g-1];
		end

		if (g == STACK_DEPTH - 1) begin : g_last
			assign pop_src = cell_q[g];
		end else begin : g_inner
			assign pop_src = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (en && do_ins) begin
				if (IDX == ins_k) begin
					cell_q[g] <= req.thread_id;
				end else if (IDX > ins_k) begin
					cell_q[g] <= ins_src;
				end
			end else if (en && do_pop) begin
				cell_q[g] <= pop_src;
			end
		end
	end

endmodule

/* hdl/backtrack_thread_stack_scheduler.sv */
// Top level of the backtrack thread stack scheduler: request and result
// stream channels around btss_stack. Depends on btss_pkg and btss_stack.
//
// Usage:
//   Requests enter on s_*: s_tuser carries the command (schedule, schedule
//   in order, next, clear), s_tdata the thread handle. Each request gives
//   exactly one result on m_*: m_tdata is the returned handle (zero unless a
//   thread came back), m_tuser holds thread_valid and overflow.
//   A request passes through the request register, then the stack update
//   and the result register together.
//   Throughput is one request per cycle while m_tready is high; every
//   command, including an in-order insert, is a single parallel update of
//   the shift-line stack, so the stack update path sets that figure.
//   When m_tready is low the result is held, and the request register
//   takes one more request only if it is empty; s_tready then drops.
//   Reset empties the active slot and the stack, sets the insert position
//   to zero and drops all valid flags; stack entries themselves are not
//   cleared, since only entries below the fill count are read.
module backtrack_thread_stack_scheduler import btss_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // thread_id
	input  logic [1:0] s_tuser,   // cmd
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // thread_out
	output logic [1:0] m_tuser    // overflow, thread_valid
);

	logic valid_s1;
	req_t req_s1;
	logic res_valid_q;
	res_t res_q;
	res_t res;
	logic advance;

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd       <= cmd_t'(s_tuser);
			req_s1.thread_id <= s_tdata;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	btss_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.req   (req_s1),
		.res   (res)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_q.thread_out;
	assign m_tuser  = {res_q.overflow, res_q.thread_valid};

endmodule

/* hdl/btss_checker.sv */
// Port-level assertions for the backtrack thread stack scheduler, and the
// bind that attaches them to the top level. No package dependency.
module btss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no returned thread means a zero handle
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("handle nonzero without a returned thread");

	// a next request never reports a dropped push
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("thread returned together with overflow");

	// an idle request side with no result showing yields no result once it has passed the request register
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) ##1 !m_tvalid |=> !m_tvalid)
		else $error("result without request");

endmodule

bind backtrack_thread_stack_scheduler btss_checker u_btss_checker (.*);
